/* rtl/core/nsas_pkg.sv */
`default_nettype none

package nsas_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_MID,
        ST_LOW,
        ST_HIGH
    } nsas_state_t;

endpackage

`default_nettype wire

/* rtl/core/nsas_store.sv */
`default_nettype none

module nsas_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [nsas_pkg::DATA_W-1:0]  wr_data,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [nsas_pkg::DATA_W-1:0]  rd_data
);

    logic [nsas_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/nsas_ctrl.sv */
`default_nettype none

module nsas_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int IW    = 11
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                search_go,
    input  wire logic signed [nsas_pkg::DATA_W-1:0]  key,
    input  wire logic [nsas_pkg::COUNT_W-1:0]        used_count,
    input  wire logic [nsas_pkg::DATA_W-1:0]         rd_data,
    output logic      [AW-1:0]                       rd_addr,
    output logic                                     busy,
    output logic                                     done,
    output logic                                     found,
    output logic      [nsas_pkg::INDEX_W-1:0]        position
);

    nsas_pkg::nsas_state_t state_reg, state_next;

    logic signed [IW-1:0] lo_reg, lo_next;
    logic signed [IW-1:0] hi_reg, hi_next;
    logic signed [IW-1:0] mid_reg, mid_next;
    logic signed [IW-1:0] size_reg, size_next;
    logic signed [nsas_pkg::DATA_W-1:0] key_reg, key_next;
    logic mid_lt_reg, mid_lt_next;
    logic done_reg, done_next;
    logic found_reg, found_next;
    logic [nsas_pkg::INDEX_W-1:0] pos_reg, pos_next;

    logic signed [IW-1:0] span;
    logic signed [IW-1:0] mid_calc;
    logic signed [IW-1:0] mid_dn;
    logic signed [IW-1:0] mid_up;
    logic signed [IW-1:0] size_clip;
    logic signed [nsas_pkg::DATA_W-1:0] entry;
    logic hit;
    logic lt_now;
    logic has_dn;
    logic has_up;

    assign span      = hi_reg - lo_reg;
    assign mid_calc  = lo_reg + (span >>> 1);
    assign mid_dn    = mid_reg - IW'(1);
    assign mid_up    = mid_reg + IW'(1);
    assign size_clip = (32'(used_count) > 32'(DEPTH)) ? IW'(DEPTH) : IW'(used_count);
    assign entry     = signed'(rd_data);
    assign hit       = (entry == key_reg);
    assign lt_now    = (entry < key_reg);
    assign has_dn    = (mid_reg >= IW'(1));
    assign has_up    = (mid_up < size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsas_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        size_reg   <= size_next;
        key_reg    <= key_next;
        mid_lt_reg <= mid_lt_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        size_next   = size_reg;
        key_next    = key_reg;
        mid_lt_next = mid_lt_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        pos_next    = pos_reg;
        rd_addr     = AW'(mid_calc);

        case (state_reg)
            nsas_pkg::ST_IDLE:
            begin
                if (search_go)
                begin
                    key_next   = key;
                    size_next  = size_clip;
                    lo_next    = '0;
                    hi_next    = size_clip - IW'(1);
                    state_next = nsas_pkg::ST_PROBE;
                end
            end

            nsas_pkg::ST_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = nsas_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr    = AW'(mid_calc);
                    mid_next   = mid_calc;
                    state_next = nsas_pkg::ST_MID;
                end
            end

            nsas_pkg::ST_MID:
            begin
                mid_lt_next = lt_now;
                if (hit)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = nsas_pkg::INDEX_W'(mid_reg);
                    state_next = nsas_pkg::ST_IDLE;
                end
                else if (has_dn)
                begin
                    rd_addr    = AW'(mid_dn);
                    state_next = nsas_pkg::ST_LOW;
                end
                else if (has_up)
                begin
                    rd_addr    = AW'(mid_up);
                    state_next = nsas_pkg::ST_HIGH;
                end
                else
                begin
                    if (lt_now)
                    begin
                        lo_next = mid_reg + IW'(2);
                    end
                    else
                    begin
                        hi_next = mid_reg - IW'(2);
                    end
                    state_next = nsas_pkg::ST_PROBE;
                end
            end

            nsas_pkg::ST_LOW:
            begin
                if (hit)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = nsas_pkg::INDEX_W'(mid_dn);
                    state_next = nsas_pkg::ST_IDLE;
                end
                else if (has_up)
                begin
                    rd_addr    = AW'(mid_up);
                    state_next = nsas_pkg::ST_HIGH;
                end
                else
                begin
                    if (mid_lt_reg)
                    begin
                        lo_next = mid_reg + IW'(2);
                    end
                    else
                    begin
                        hi_next = mid_reg - IW'(2);
                    end
                    state_next = nsas_pkg::ST_PROBE;
                end
            end

            nsas_pkg::ST_HIGH:
            begin
                if (hit)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = nsas_pkg::INDEX_W'(mid_up);
                    state_next = nsas_pkg::ST_IDLE;
                end
                else
                begin
                    if (mid_lt_reg)
                    begin
                        lo_next = mid_reg + IW'(2);
                    end
                    else
                    begin
                        hi_next = mid_reg - IW'(2);
                    end
                    state_next = nsas_pkg::ST_PROBE;
                end
            end

            default:
            begin
                state_next = nsas_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != nsas_pkg::ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = pos_reg;

endmodule

`default_nettype wire

/* rtl/core/nearly_sorted_array_search_top.sv */
`default_nettype none

// Search in a nearly sorted array. Issue a request by raising start while busy
// is low: func selects a load (write element_value at load_index, no result)
// or a search (look up search_key among the first used_count entries, where
// each entry sits at most one place from its sorted slot). A load finishes in
// the cycle it is taken. A search drives one result: done pulses high for
// exactly one cycle with found and position valid in that same cycle, and
// there is no way to stall it, so capture it when done is high. Each probe of
// the binary search forms the midpoint and reads entry mid through the single
// read port of the element store, then compares mid, mid-1 and mid+1 as their
// reads return one after another. A search takes at most seven probes over
// 256 entries, and busy stays high until the result is out. Write used_count
// only while busy is low and no result is pending; counts above the store
// depth are clipped to it. Loads beyond the store are dropped. The store has
// no reset: search only entries that were loaded.
module nearly_sorted_array_search_top #(
    parameter int STORE_DEPTH = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                func,
    input  wire logic [nsas_pkg::INDEX_W-1:0]        load_index,
    input  wire logic signed [nsas_pkg::DATA_W-1:0]  element_value,
    input  wire logic signed [nsas_pkg::DATA_W-1:0]  search_key,
    input  wire logic                                used_count_wr,
    input  wire logic [nsas_pkg::COUNT_W-1:0]        used_count_data,
    output logic                                     done,
    output logic                                     found,
    output logic      [nsas_pkg::INDEX_W-1:0]        position
);

    // address width of the store; index width covers -2 .. depth+3, signed
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IW = AW + 3;

    logic [nsas_pkg::COUNT_W-1:0] used_count_reg;

    logic                         take;
    logic                         load_wr;
    logic                         search_go;
    logic [AW-1:0]                rd_addr;
    logic [nsas_pkg::DATA_W-1:0]  rd_data;

    // hold the search window length; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (used_count_wr)
        begin
            used_count_reg <= used_count_data;
        end
    end

    // accept a request; drop loads that fall outside the store
    assign take      = start && !busy;
    assign load_wr   = take && (func == nsas_pkg::FUNC_LOAD)
                       && (32'(load_index) < 32'(STORE_DEPTH));
    assign search_go = take && (func == nsas_pkg::FUNC_SEARCH);

    nsas_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (AW'(load_index)),
        .wr_data (element_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nsas_ctrl #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .IW    (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .search_go  (search_go),
        .key        (search_key),
        .used_count (used_count_reg),
        .rd_data    (rd_data),
        .rd_addr    (rd_addr),
        .busy       (busy),
        .done       (done),
        .found      (found),
        .position   (position)
    );

endmodule

`default_nettype wire
